// File: hdl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Types and codes shared by the priority task scheduler files.
// ----------------------------------------------------------------------------
package psc_pkg;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_START   = 3'd1,
    OP_TICK    = 3'd2,
    OP_DELAY   = 3'd3,
    OP_SUSPEND = 3'd4,
    OP_POST    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  task_index;
    logic [15:0] delay_ticks;
  } in_item_t;

  typedef struct packed {
    logic [2:0] current_task;
    logic [2:0] highest_ready;
    logic       switched;
    logic [7:0] ready_map;
  } out_item_t;

  // per-counter update control seen at the head of the ring
  typedef struct packed {
    logic tick;
    logic clear;
    logic load;
  } head_ctrl_t;

endpackage

// File: hdl/psc_cell.sv
// ----------------------------------------------------------------------------
// psc_cell
// One delay counter of the ring; takes its neighbor's count on each shift.
// ----------------------------------------------------------------------------
module psc_cell #(
  parameter int DELAY_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic [DELAY_BITS-1:0] cnt_i,
  output logic [DELAY_BITS-1:0] cnt_o
);

  logic [DELAY_BITS-1:0] cnt_q;
  logic [DELAY_BITS-1:0] cnt_d;

  assign cnt_d = shift_i ? cnt_i : cnt_q;
  assign cnt_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: hdl/psc_head.sv
// ----------------------------------------------------------------------------
// psc_head
// Update stage between the tail and the head of the counter ring.
// ----------------------------------------------------------------------------
module psc_head #(
  parameter int DELAY_BITS = 16
) (
  input  psc_pkg::head_ctrl_t   ctrl_i,
  input  logic [DELAY_BITS-1:0] load_val_i,
  input  logic [DELAY_BITS-1:0] cnt_i,
  output logic [DELAY_BITS-1:0] cnt_o,
  output logic                  fire_o
);

  logic nonzero;

  assign nonzero = (cnt_i != '0);

  always_comb begin
    cnt_o  = cnt_i;
    fire_o = 1'b0;
    if (ctrl_i.clear) begin
      cnt_o = '0;
    end else if (ctrl_i.load) begin
      cnt_o = load_val_i;
    end else if (ctrl_i.tick && nonzero) begin
      cnt_o  = cnt_i - DELAY_BITS'(1);
      fire_o = (cnt_i == DELAY_BITS'(1));
    end
  end

endmodule

// File: hdl/priority_task_scheduler_core.sv
// ----------------------------------------------------------------------------
// priority_task_scheduler_core
// Ready-bitmap task scheduler with one tick delay counter per task.
// ----------------------------------------------------------------------------
// Each item is accepted in ST_IDLE and then walks the delay counters: they sit
// in a ring of cells that rotates once per item, one counter passing the update
// stage each cycle in ST_WALK, then ST_DONE reschedules and loads the result
// register. A new item is accepted in the cycle after the result is loaded,
// even while that result still waits, but not before the last item is through
// ST_DONE. A result that is still waiting when the next item finishes its walk
// holds that item until it is taken.
// No clearing pass after reset.
module priority_task_scheduler_core #(
  parameter int NUM_TASKS  = 8,
  parameter int DELAY_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  psc_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output psc_pkg::out_item_t  out_item_o
);

  localparam int TW = $clog2(NUM_TASKS);

  psc_pkg::state_e state_q, state_d;

  logic [2:0]            op_q;
  logic [2:0]            idx_q;
  logic [DELAY_BITS-1:0] ticks_q;
  logic [TW-1:0]         cur_q;
  logic [TW-1:0]         ptr_q, ptr_d;

  logic [NUM_TASKS-1:0]  ready_q, ready_d;
  logic [TW-1:0]         run_q, run_d;
  logic [TW-1:0]         hi_q, hi_d;

  logic                  out_valid_q;
  psc_pkg::out_item_t    out_q;

  logic                  accept;
  logic                  shift;
  logic                  commit;
  logic                  sw;
  logic [TW-1:0]         lowest;
  logic                  idx_ok;
  logic [31:0]           ticks_wide;

  logic [DELAY_BITS-1:0] cnt [NUM_TASKS];
  logic [DELAY_BITS-1:0] head_cnt;
  logic                  head_fire;
  psc_pkg::head_ctrl_t   head_ctrl;

  // ring of counters
  for (genvar k = 0; k < NUM_TASKS; k++) begin : g_cell
    psc_cell #(.DELAY_BITS(DELAY_BITS)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .cnt_i   ((k == 0) ? head_cnt : cnt[(k + NUM_TASKS - 1) % NUM_TASKS]),
      .cnt_o   (cnt[k])
    );
  end

  assign head_ctrl.tick  = (op_q == psc_pkg::OP_TICK);
  assign head_ctrl.clear = (op_q == psc_pkg::OP_CREATE) && (idx_q == 3'(ptr_q));
  assign head_ctrl.load  = (op_q == psc_pkg::OP_DELAY) && (cur_q == ptr_q);

  psc_head #(.DELAY_BITS(DELAY_BITS)) u_head (
    .ctrl_i     (head_ctrl),
    .load_val_i (ticks_q),
    .cnt_i      (cnt[NUM_TASKS-1]),
    .cnt_o      (head_cnt),
    .fire_o     (head_fire)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      psc_pkg::ST_IDLE: if (in_valid_i) state_d = psc_pkg::ST_WALK;
      psc_pkg::ST_WALK: if (ptr_q == '0) state_d = psc_pkg::ST_DONE;
      psc_pkg::ST_DONE: if (!out_valid_q || out_ready_i) state_d = psc_pkg::ST_IDLE;
      default:          state_d = psc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    shift      = 1'b0;
    commit     = 1'b0;
    case (state_q)
      psc_pkg::ST_IDLE: in_ready_o = 1'b1;
      psc_pkg::ST_WALK: shift      = 1'b1;
      psc_pkg::ST_DONE: commit     = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign accept     = in_valid_i && in_ready_o;
  assign idx_ok     = ({1'b0, in_item_i.task_index} < 4'(NUM_TASKS));
  assign ticks_wide = {16'b0, in_item_i.delay_ticks};

  // lowest set ready bit, idle index when empty
  always_comb begin
    lowest = TW'(NUM_TASKS - 1);
    for (int i = NUM_TASKS - 1; i >= 0; i--) begin
      if (ready_q[i]) lowest = TW'(i);
    end
  end

  always_comb begin
    ready_d = ready_q;
    if (accept) begin
      case (in_item_i.op)
        psc_pkg::OP_CREATE,
        psc_pkg::OP_POST: if (idx_ok) ready_d[in_item_i.task_index[TW-1:0]] = 1'b1;
        psc_pkg::OP_DELAY,
        psc_pkg::OP_SUSPEND: ready_d[run_q] = 1'b0;
        default: ;
      endcase
    end else if (shift && head_fire) begin
      ready_d[ptr_q] = 1'b1;
    end
  end

  always_comb begin
    run_d = run_q;
    hi_d  = hi_q;
    sw    = 1'b0;
    case (op_q)
      psc_pkg::OP_START: begin
        run_d = lowest;
        hi_d  = lowest;
      end
      psc_pkg::OP_TICK, psc_pkg::OP_DELAY, psc_pkg::OP_SUSPEND, psc_pkg::OP_POST: begin
        run_d = lowest;
        hi_d  = lowest;
        sw    = (lowest != run_q);
      end
      default: ;
    endcase
  end

  assign ptr_d = accept ? TW'(NUM_TASKS - 1) : (shift ? ptr_q - TW'(1) : ptr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psc_pkg::ST_IDLE;
      ptr_q       <= '0;
      ready_q     <= '0;
      run_q       <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      ready_q <= ready_d;
      if (commit) begin
        run_q       <= run_d;
        hi_q        <= hi_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_item_i.op;
      idx_q   <= in_item_i.task_index;
      ticks_q <= ticks_wide[DELAY_BITS-1:0];
      cur_q   <= run_q;
    end
    if (commit) begin
      out_q.current_task  <= 3'(run_d);
      out_q.highest_ready <= 3'(hi_d);
      out_q.switched      <= sw;
      out_q.ready_map     <= 8'(ready_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: hdl/psc_checker.sv
// ----------------------------------------------------------------------------
// psc_checker
// Port-level checks for the priority task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module psc_checker #(
  parameter int NUM_TASKS = 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input psc_pkg::out_item_t out_item_o
);

  // result stays up until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result dropped or changed while stalled");

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while another is in flight");

  // a switch always lands on the highest ready task
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.switched |->
      out_item_o.current_task == out_item_o.highest_ready)
    else $error("switch to a task other than the highest ready");

  // empty bitmap after a switch means the idle task runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.switched && (out_item_o.ready_map == 8'd0) |->
      out_item_o.current_task == 3'(NUM_TASKS - 1))
    else $error("switch with empty bitmap not to idle task");

endmodule

bind priority_task_scheduler_core psc_checker #(.NUM_TASKS(NUM_TASKS)) u_psc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
